/* rtl/flaa_pkg.sv */
package flaa_pkg;

   // Default arena geometry.
   localparam int ARENA_UNITS_DEF = 65536;
   localparam int UNIT_BYTES_DEF  = 16;

   // Fixed field widths.
   localparam int REQ_BYTES_W = 20;
   localparam int ADDR_W      = 16;
   localparam int STATUS_W    = 2;
   localparam int NEED_W      = REQ_BYTES_W + 1;

   // Packed stream widths.
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_TUSER_W = 2;

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_BAD_FREE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_A_BEGIN,
      S_A_ROVER,
      S_A_WALK,
      S_F_BEGIN,
      S_F_SIZE,
      S_F_WALK,
      S_F_NEXT,
      S_WRITE,
      S_DONE
   } state_type;

   // Field write enables of one header word.
   typedef struct packed {
      logic nxt;
      logic prv;
      logic siz;
   } wr_mask_type;

   // One finished result word.
   typedef struct packed {
      logic [ADDR_W-1:0] granted_address;
      status_type        status;
   } result_type;

endpackage

/* rtl/flaa_hdr_ram.sv */
module flaa_hdr_ram #(
   parameter int DEPTH = flaa_pkg::ARENA_UNITS_DEF,
   parameter int IW    = $clog2(flaa_pkg::ARENA_UNITS_DEF),
   parameter int LW    = $clog2(flaa_pkg::ARENA_UNITS_DEF) + 1
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [IW-1:0]         rd_addr,
   output logic [LW-1:0]         rd_next,
   output logic [LW-1:0]         rd_prev,
   output logic [IW-1:0]         rd_size,
   input  logic                  wr_en,
   input  logic [IW-1:0]         wr_addr,
   input  flaa_pkg::wr_mask_type wr_mask,
   input  logic [LW-1:0]         wr_next,
   input  logic [LW-1:0]         wr_prev,
   input  logic [IW-1:0]         wr_size
);

   localparam int DW = 2 * LW + IW;

   // Header word: next link on top, prev link in the middle, size at the bottom.
   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_q_ff;

   // Field-masked write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_mask.siz) mem[wr_addr][IW-1:0] <= wr_size;
         if (wr_mask.prv) mem[wr_addr][IW+LW-1:IW] <= wr_prev;
         if (wr_mask.nxt) mem[wr_addr][DW-1:IW+LW] <= wr_next;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   assign rd_size = rd_q_ff[IW-1:0];
   assign rd_prev = rd_q_ff[IW+LW-1:IW];
   assign rd_next = rd_q_ff[DW-1:IW+LW];

endmodule

/* rtl/flaa_ctrl.sv */
module flaa_ctrl #(
   parameter int ARENA_UNITS = flaa_pkg::ARENA_UNITS_DEF,
   parameter int UNIT_BYTES  = flaa_pkg::UNIT_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  flaa_pkg::mode_type                  mode,
   input  logic [flaa_pkg::REQ_BYTES_W-1:0]    request_bytes,
   input  logic [flaa_pkg::ADDR_W-1:0]         block_address,
   output logic                                idle,
   output logic                                done,
   output flaa_pkg::result_type                result,
   input  logic                                take
);

   localparam int IW   = $clog2(ARENA_UNITS);
   localparam int LW   = IW + 1;
   localparam int NW   = flaa_pkg::NEED_W;
   localparam int CW   = ((LW > NW) ? LW : NW) + 1;
   localparam logic [LW-1:0] SENT = LW'(ARENA_UNITS);
   localparam logic [IW-1:0] FULL = IW'(ARENA_UNITS - 1);

   flaa_pkg::state_type state_ff, state_in;

   // Control registers.
   logic              started_ff, started_in;
   logic [LW-1:0]     rover_ff, rover_in;
   logic [LW-1:0]     sn_ff, sn_in;
   logic [LW-1:0]     sp_ff, sp_in;
   logic              sel_ff, sel_in;
   logic [LW-1:0]     steps_ff, steps_in;
   logic [1:0]        wq_cnt_ff, wq_cnt_in;

   // Payload registers.
   logic [NW-1:0]     need_ff, need_in;
   logic [flaa_pkg::ADDR_W-1:0] baddr_ff, baddr_in;
   logic [LW-1:0]     p_ff, p_in;
   logic [LW-1:0]     n_ff, n_in;
   logic [LW-1:0]     bp_ff, bp_in;
   logic [IW-1:0]     bsz_ff, bsz_in;
   logic [IW-1:0]     psz_ff, psz_in;
   flaa_pkg::result_type res_ff, res_in;

   // Pending header writes, issued one per cycle from slot zero.
   logic [LW-1:0]         wq_addr_ff [3];
   logic [LW-1:0]         wq_addr_in [3];
   flaa_pkg::wr_mask_type wq_mask_ff [3];
   flaa_pkg::wr_mask_type wq_mask_in [3];
   logic [LW-1:0]         wq_next_ff [3];
   logic [LW-1:0]         wq_next_in [3];
   logic [LW-1:0]         wq_prev_ff [3];
   logic [LW-1:0]         wq_prev_in [3];
   logic [IW-1:0]         wq_size_ff [3];
   logic [IW-1:0]         wq_size_in [3];

   // Memory ports.
   logic                  rd_go;
   logic [LW-1:0]         rd_full;
   logic                  rd_en;
   logic [LW-1:0]         rd_next, rd_prev;
   logic [IW-1:0]         rd_size;
   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   flaa_pkg::wr_mask_type wr_mask;
   logic [LW-1:0]         wr_next, wr_prev;
   logic [IW-1:0]         wr_size;

   // Header of the node read last cycle; the sentinel lives in registers.
   logic [LW-1:0] h_next, h_prev;
   logic [IW-1:0] h_size;

   logic [NW-1:0] bytes1;
   logic [NW-1:0] rounded;
   logic [IW-1:0] rem;
   logic [LW-1:0] newp;
   logic [CW-1:0] bend;
   logic          upper, lower;

   assign h_next = sel_ff ? sn_ff : rd_next;
   assign h_prev = sel_ff ? sp_ff : rd_prev;
   assign h_size = sel_ff ? '0 : rd_size;

   flaa_hdr_ram #(
      .DEPTH (ARENA_UNITS),
      .IW    (IW),
      .LW    (LW)
   ) u_hdr_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_full[IW-1:0]),
      .rd_next (rd_next),
      .rd_prev (rd_prev),
      .rd_size (rd_size),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_mask (wr_mask),
      .wr_next (wr_next),
      .wr_prev (wr_prev),
      .wr_size (wr_size)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= flaa_pkg::S_IDLE;
         started_ff <= 1'b0;
         rover_ff   <= SENT;
         sn_ff      <= '0;
         sp_ff      <= '0;
         sel_ff     <= 1'b0;
         steps_ff   <= '0;
         wq_cnt_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
         rover_ff   <= rover_in;
         sn_ff      <= sn_in;
         sp_ff      <= sp_in;
         sel_ff     <= sel_in;
         steps_ff   <= steps_in;
         wq_cnt_ff  <= wq_cnt_in;
      end
   end

   // Payload state.
   always_ff @(posedge clock) begin
      need_ff  <= need_in;
      baddr_ff <= baddr_in;
      p_ff     <= p_in;
      n_ff     <= n_in;
      bp_ff    <= bp_in;
      bsz_ff   <= bsz_in;
      psz_ff   <= psz_in;
      res_ff   <= res_in;
      for (int i = 0; i < 3; i++) begin
         wq_addr_ff[i] <= wq_addr_in[i];
         wq_mask_ff[i] <= wq_mask_in[i];
         wq_next_ff[i] <= wq_next_in[i];
         wq_prev_ff[i] <= wq_prev_in[i];
         wq_size_ff[i] <= wq_size_in[i];
      end
   end

   // Request decode, list walk and write sequencing.
   always_comb begin
      state_in   = state_ff;
      started_in = started_ff;
      rover_in   = rover_ff;
      sn_in      = sn_ff;
      sp_in      = sp_ff;
      steps_in   = steps_ff;
      wq_cnt_in  = wq_cnt_ff;
      need_in    = need_ff;
      baddr_in   = baddr_ff;
      p_in       = p_ff;
      n_in       = n_ff;
      bp_in      = bp_ff;
      bsz_in     = bsz_ff;
      psz_in     = psz_ff;
      res_in     = res_ff;
      for (int i = 0; i < 3; i++) begin
         wq_addr_in[i] = wq_addr_ff[i];
         wq_mask_in[i] = wq_mask_ff[i];
         wq_next_in[i] = wq_next_ff[i];
         wq_prev_in[i] = wq_prev_ff[i];
         wq_size_in[i] = wq_size_ff[i];
      end
      rd_go   = 1'b0;
      rd_full = SENT;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_mask = '0;
      wr_next = wq_next_ff[0];
      wr_prev = wq_prev_ff[0];
      wr_size = wq_size_ff[0];

      bytes1  = (request_bytes == '0) ? NW'(1) : NW'(request_bytes);
      rounded = bytes1 + NW'(UNIT_BYTES - 1);
      rem     = IW'(CW'(h_size) - CW'(need_ff));
      newp    = LW'(CW'(p_ff) + CW'(rem));
      bend    = CW'(bp_ff) + CW'(bsz_ff);
      upper   = (n_ff != SENT) && (bend == CW'(n_ff));
      lower   = (p_ff != SENT) && (CW'(p_ff) + CW'(psz_ff) == CW'(bp_ff));

      unique case (state_ff)
         flaa_pkg::S_IDLE: begin
            if (start) begin
               need_in  = NW'(rounded / NW'(UNIT_BYTES)) + NW'(1);
               baddr_in = block_address;
               state_in = (mode == flaa_pkg::MODE_ALLOC) ? flaa_pkg::S_A_BEGIN
                                                         : flaa_pkg::S_F_BEGIN;
            end
         end

         // Lazy list setup, size check and read of the rover.
         flaa_pkg::S_A_BEGIN: begin
            if (!started_ff) begin
               wr_en      = 1'b1;
               wr_addr    = '0;
               wr_mask    = '{nxt: 1'b1, prv: 1'b1, siz: 1'b1};
               wr_next    = SENT;
               wr_prev    = SENT;
               wr_size    = FULL;
               started_in = 1'b1;
               rover_in   = SENT;
            end
            if (CW'(need_ff) > CW'(FULL)) begin
               res_in   = '{granted_address: '0, status: flaa_pkg::ST_NO_SPACE};
               state_in = flaa_pkg::S_DONE;
            end else begin
               rd_go    = 1'b1;
               rd_full  = started_ff ? rover_ff : SENT;
               state_in = flaa_pkg::S_A_ROVER;
            end
         end

         flaa_pkg::S_A_ROVER: begin
            p_in     = h_next;
            steps_in = '0;
            rd_go    = 1'b1;
            rd_full  = h_next;
            state_in = flaa_pkg::S_A_WALK;
         end

         // One free block per cycle until one fits or none is left.
         flaa_pkg::S_A_WALK: begin
            if (CW'(steps_ff) > CW'(ARENA_UNITS)) begin
               res_in   = '{granted_address: '0, status: flaa_pkg::ST_NO_SPACE};
               state_in = flaa_pkg::S_DONE;
            end else if (CW'(h_size) >= CW'(need_ff)) begin
               rover_in  = h_prev;
               wq_cnt_in = 2'd2;
               state_in  = flaa_pkg::S_WRITE;
               if (CW'(h_size) == CW'(need_ff)) begin
                  // Exact fit: unlink the block.
                  wq_addr_in[0] = h_prev;
                  wq_mask_in[0] = '{nxt: 1'b1, prv: 1'b0, siz: 1'b0};
                  wq_next_in[0] = h_next;
                  wq_addr_in[1] = h_next;
                  wq_mask_in[1] = '{nxt: 1'b0, prv: 1'b1, siz: 1'b0};
                  wq_prev_in[1] = h_prev;
                  res_in = '{granted_address: flaa_pkg::ADDR_W'(CW'(p_ff) + CW'(1)),
                             status: flaa_pkg::ST_OK};
               end else begin
                  // Carve the tail off the block.
                  wq_addr_in[0] = p_ff;
                  wq_mask_in[0] = '{nxt: 1'b0, prv: 1'b0, siz: 1'b1};
                  wq_size_in[0] = rem;
                  wq_addr_in[1] = newp;
                  wq_mask_in[1] = '{nxt: 1'b0, prv: 1'b0, siz: 1'b1};
                  wq_size_in[1] = IW'(need_ff);
                  res_in = '{granted_address: flaa_pkg::ADDR_W'(CW'(newp) + CW'(1)),
                             status: flaa_pkg::ST_OK};
               end
            end else if (p_ff == rover_ff) begin
               res_in   = '{granted_address: '0, status: flaa_pkg::ST_NO_SPACE};
               state_in = flaa_pkg::S_DONE;
            end else begin
               p_in     = h_next;
               steps_in = steps_ff + LW'(1);
               rd_go    = 1'b1;
               rd_full  = h_next;
            end
         end

         flaa_pkg::S_F_BEGIN: begin
            if (!started_ff || baddr_ff == '0 || CW'(baddr_ff) >= CW'(SENT)) begin
               res_in   = '{granted_address: '0, status: flaa_pkg::ST_BAD_FREE};
               state_in = flaa_pkg::S_DONE;
            end else begin
               bp_in    = LW'(CW'(baddr_ff) - CW'(1));
               rd_go    = 1'b1;
               rd_full  = LW'(CW'(baddr_ff) - CW'(1));
               state_in = flaa_pkg::S_F_SIZE;
            end
         end

         // Size of the block being freed, then start at the sentinel.
         flaa_pkg::S_F_SIZE: begin
            bsz_in = h_size;
            if (h_size == '0 || CW'(bp_ff) + CW'(h_size) > CW'(SENT)) begin
               res_in   = '{granted_address: '0, status: flaa_pkg::ST_BAD_FREE};
               state_in = flaa_pkg::S_DONE;
            end else begin
               p_in     = SENT;
               steps_in = '0;
               rd_go    = 1'b1;
               rd_full  = SENT;
               state_in = flaa_pkg::S_F_WALK;
            end
         end

         // Find the free neighbors below and above the block.
         flaa_pkg::S_F_WALK: begin
            if (CW'(steps_ff) > CW'(ARENA_UNITS)) begin
               res_in   = '{granted_address: '0, status: flaa_pkg::ST_BAD_FREE};
               state_in = flaa_pkg::S_DONE;
            end else if (h_next >= SENT || CW'(h_next) >= CW'(bp_ff)) begin
               n_in   = (h_next >= SENT) ? SENT : h_next;
               psz_in = h_size;
               if ((h_next < SENT && CW'(h_next) < bend) ||
                   (p_ff != SENT && CW'(p_ff) + CW'(h_size) > CW'(bp_ff))) begin
                  res_in   = '{granted_address: '0, status: flaa_pkg::ST_BAD_FREE};
                  state_in = flaa_pkg::S_DONE;
               end else begin
                  rd_go    = 1'b1;
                  rd_full  = (h_next >= SENT) ? SENT : h_next;
                  state_in = flaa_pkg::S_F_NEXT;
               end
            end else begin
               p_in     = h_next;
               steps_in = steps_ff + LW'(1);
               rd_go    = 1'b1;
               rd_full  = h_next;
            end
         end

         // Upper neighbor header is here: queue the merge or the insert.
         flaa_pkg::S_F_NEXT: begin
            rover_in = p_ff;
            res_in   = '{granted_address: '0, status: flaa_pkg::ST_OK};
            state_in = flaa_pkg::S_WRITE;
            if (upper && lower) begin
               wq_addr_in[0] = p_ff;
               wq_mask_in[0] = '{nxt: 1'b1, prv: 1'b0, siz: 1'b1};
               wq_size_in[0] = IW'(CW'(psz_ff) + CW'(bsz_ff) + CW'(h_size));
               wq_next_in[0] = h_next;
               wq_addr_in[1] = h_next;
               wq_mask_in[1] = '{nxt: 1'b0, prv: 1'b1, siz: 1'b0};
               wq_prev_in[1] = p_ff;
               wq_cnt_in     = 2'd2;
            end else if (lower) begin
               wq_addr_in[0] = p_ff;
               wq_mask_in[0] = '{nxt: 1'b0, prv: 1'b0, siz: 1'b1};
               wq_size_in[0] = IW'(CW'(psz_ff) + CW'(bsz_ff));
               wq_cnt_in     = 2'd1;
            end else begin
               wq_addr_in[0] = bp_ff;
               wq_mask_in[0] = '{nxt: 1'b1, prv: 1'b1, siz: 1'b1};
               wq_next_in[0] = upper ? h_next : n_ff;
               wq_prev_in[0] = p_ff;
               wq_size_in[0] = upper ? IW'(CW'(bsz_ff) + CW'(h_size)) : bsz_ff;
               wq_addr_in[1] = upper ? h_next : n_ff;
               wq_mask_in[1] = '{nxt: 1'b0, prv: 1'b1, siz: 1'b0};
               wq_prev_in[1] = bp_ff;
               wq_addr_in[2] = p_ff;
               wq_mask_in[2] = '{nxt: 1'b1, prv: 1'b0, siz: 1'b0};
               wq_next_in[2] = bp_ff;
               wq_cnt_in     = 2'd3;
            end
         end

         // Drain the write queue; sentinel links go to registers.
         flaa_pkg::S_WRITE: begin
            if (wq_addr_ff[0] == SENT) begin
               if (wq_mask_ff[0].nxt) sn_in = wq_next_ff[0];
               if (wq_mask_ff[0].prv) sp_in = wq_prev_ff[0];
            end else begin
               wr_en   = 1'b1;
               wr_addr = wq_addr_ff[0][IW-1:0];
               wr_mask = wq_mask_ff[0];
            end
            for (int i = 0; i < 2; i++) begin
               wq_addr_in[i] = wq_addr_ff[i+1];
               wq_mask_in[i] = wq_mask_ff[i+1];
               wq_next_in[i] = wq_next_ff[i+1];
               wq_prev_in[i] = wq_prev_ff[i+1];
               wq_size_in[i] = wq_size_ff[i+1];
            end
            wq_cnt_in = wq_cnt_ff - 2'd1;
            if (wq_cnt_ff == 2'd1) begin
               state_in = flaa_pkg::S_DONE;
            end
         end

         flaa_pkg::S_DONE: begin
            if (take) begin
               state_in = flaa_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = flaa_pkg::S_IDLE;
         end
      endcase

      rd_en  = rd_go && (rd_full != SENT);
      sel_in = rd_go ? (rd_full == SENT) : sel_ff;
   end

   assign idle   = (state_ff == flaa_pkg::S_IDLE);
   assign done   = (state_ff == flaa_pkg::S_DONE);
   assign result = res_ff;

endmodule

/* rtl/free_list_arena_allocator.sv */
// Channel  Dir  Word contents (low bit first)
// req_     in   tuser: mode; tdata: request_bytes[19:0], block_address[35:20]
// rsp_     out  tuser: status; tdata: granted_address[15:0]
//
// One request is in work at a time. An allocation walks the free blocks from the
// rover, then makes two header updates; a free walks the free blocks below it,
// then makes one to three header updates. The list walk is bound by the single
// read port of the header memory. Reset is synchronous; the header memory is not
// cleared and is set up on the first allocation. A result waits in the output
// register while the next request is taken in; a stalled result holds only the
// finishing step.
module free_list_arena_allocator #(
   parameter int ARENA_UNITS = flaa_pkg::ARENA_UNITS_DEF,
   parameter int UNIT_BYTES  = flaa_pkg::UNIT_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [flaa_pkg::REQ_TDATA_W-1:0] req_tdata,  // request_bytes, block_address
   input  logic [flaa_pkg::REQ_TUSER_W-1:0] req_tuser,  // mode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [flaa_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // granted_address
   output logic [flaa_pkg::RSP_TUSER_W-1:0] rsp_tuser   // status
);

   logic                 idle, done, take, start;
   flaa_pkg::result_type result;
   logic                 rsp_valid_ff, rsp_valid_in;
   flaa_pkg::result_type rsp_word_ff, rsp_word_in;

   assign req_tready = idle;
   assign start      = req_tvalid && idle;
   assign take       = done && (!rsp_valid_ff || rsp_tready);

   flaa_ctrl #(
      .ARENA_UNITS (ARENA_UNITS),
      .UNIT_BYTES  (UNIT_BYTES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .mode          (flaa_pkg::mode_type'(req_tuser[0])),
      .request_bytes (req_tdata[flaa_pkg::REQ_BYTES_W-1:0]),
      .block_address (req_tdata[flaa_pkg::REQ_BYTES_W+flaa_pkg::ADDR_W-1:
                                flaa_pkg::REQ_BYTES_W]),
      .idle          (idle),
      .done          (done),
      .result        (result),
      .take          (take)
   );

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff.granted_address;
   assign rsp_tuser  = rsp_word_ff.status;

endmodule

/* rtl/flaa_checker.sv */
module flaa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [flaa_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [flaa_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // A failed request never carries an address.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != flaa_pkg::ST_OK |-> rsp_tdata == '0)
      else $error("failed request carries an address");

   // Once a request is taken, the block is busy in the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request port open right after a request");

endmodule

bind free_list_arena_allocator flaa_checker u_flaa_checker (.*);
